FILE: hw/rtl/vn_pkg.sv
// Shared widths, payload types and arithmetic step functions for the
// 2D vector normalizer. No dependencies; every other file uses it by scope.
`timescale 1ns / 1ps
`default_nettype none

package vn_pkg;

    localparam int IN_W   = 16;              // input component width, Q7.8
    localparam int FRAC_W = 14;              // fraction bits of a unit component
    localparam int OUT_W  = FRAC_W + 2;      // unit component width, Q1.14
    localparam int SQ_W   = 2 * IN_W;        // sum of squares width
    localparam int ROOT_W = IN_W;            // square root width
    localparam int REM_W  = ROOT_W + 3;      // square root partial remainder
    localparam int Q_W    = FRAC_W + 1;      // quotient width, covers 1.0
    localparam int NUM_W  = IN_W + FRAC_W + 1; // scaled numerator with rounding term

    localparam logic [Q_W-1:0] Q_ONE = {1'b1, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic                    req_type;
        logic signed [IN_W-1:0]  vec_x;
        logic signed [IN_W-1:0]  vec_y;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] unit_x;
        logic signed [OUT_W-1:0] unit_y;
        logic [ROOT_W-1:0]       magnitude;
        logic                    zero_length;
    } t_out;

    // Sideband that travels through the square root pipeline
    typedef struct packed {
        logic            semi;
        logic            xneg;
        logic            yneg;
        logic [IN_W-1:0] xm;
        logic [IN_W-1:0] ym;
    } t_side;

    // Per-lane flags that travel through a divider lane
    typedef struct packed {
        logic semi;
        logic mag_nz;
        logic neg;
    } t_tag;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq_step;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic              qbit;
    } t_div_step;

    // One digit of the bit-pair square root recurrence
    function automatic t_sq_step sqrt_step(input logic [REM_W-1:0] rem,
                                           input logic [ROOT_W-1:0] root,
                                           input logic [1:0] pair);
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] trial;
        t_sq_step         res;
        t     = {rem[REM_W-3:0], pair};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, root, 2'b01};
        if (t >= trial) begin
            res.rem  = t - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = t;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // One bit of restoring division
    function automatic t_div_step div_step(input logic [ROOT_W-1:0] rem,
                                           input logic [ROOT_W-1:0] len,
                                           input logic nb);
        logic [ROOT_W:0] t;
        logic [ROOT_W:0] d;
        t_div_step       res;
        t = {rem, nb};
        d = t - {1'b0, len};
        if (t >= {1'b0, len}) begin
            res.rem  = d[ROOT_W-1:0];
            res.qbit = 1'b1;
        end else begin
            res.rem  = t[ROOT_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vector2_normalizer_core.sv
// Top level of the 2D vector normalizer: front end, square root, two divider
// lanes and merge. Depends on vn_pkg, vn_sqrt, vn_div_lane and vn_merge.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_data carries a mode bit and a
//   signed Q7.8 vector. Output channel o_out_valid / i_out_stall / o_out_data
//   carries the Q1.14 unit components, the UQ8.8 floor length and a zero flag.
//   A transaction moves at an edge where valid is high and stall is low.
//   Abs, square and sum registers feed the square root stages (one root bit
//   per stage), the divider lane stages (one quotient bit per stage) and the
//   merge register. One transaction per cycle is sustained while the receiver
//   does not stall; the x and y quotients are computed in parallel lanes.
//   The whole pipeline advances together while the output register is empty
//   or being taken. When the receiver stalls with a result waiting, the
//   whole pipeline holds and o_in_stall rises until the result is taken.
//   Reset clears all valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module vector2_normalizer_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire vn_pkg::t_in  i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output vn_pkg::t_out      o_out_data
);

    logic                      w_en;
    logic [vn_pkg::IN_W-1:0]   n_xm;
    logic [vn_pkg::IN_W-1:0]   n_ym;

    logic                      r_v0;
    vn_pkg::t_side             r_side0;
    logic                      r_v1;
    vn_pkg::t_side             r_side1;
    logic [vn_pkg::SQ_W-1:0]   r_sqx;
    logic [vn_pkg::SQ_W-1:0]   r_sqy;
    logic                      r_v2;
    vn_pkg::t_side             r_side2;
    logic [vn_pkg::SQ_W-1:0]   r_rad;

    logic                      w_sq_valid;
    logic [vn_pkg::ROOT_W-1:0] w_root;
    vn_pkg::t_side             w_side;
    vn_pkg::t_tag              w_tagx_in;
    vn_pkg::t_tag              w_tagy_in;

    logic                      w_dx_valid;
    logic [vn_pkg::Q_W-1:0]    w_qx;
    logic [vn_pkg::Q_W-1:0]    w_qy;
    logic [vn_pkg::ROOT_W-1:0] w_len;
    vn_pkg::t_tag              w_tagx;
    vn_pkg::t_tag              w_tagy;

    // advance the pipeline unless a waiting result is stalled
    assign w_en       = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    // absolute values; the most negative code wraps to its full magnitude
    assign n_xm = i_in_data.vec_x[vn_pkg::IN_W-1] ? (vn_pkg::IN_W'(0) - i_in_data.vec_x)
                                                  : i_in_data.vec_x;
    assign n_ym = i_in_data.vec_y[vn_pkg::IN_W-1] ? (vn_pkg::IN_W'(0) - i_in_data.vec_y)
                                                  : i_in_data.vec_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // front end: abs, square, sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side0.semi <= i_in_data.req_type;
            r_side0.xneg <= i_in_data.vec_x[vn_pkg::IN_W-1];
            r_side0.yneg <= i_in_data.vec_y[vn_pkg::IN_W-1];
            r_side0.xm   <= n_xm;
            r_side0.ym   <= n_ym;
            r_side1      <= r_side0;
            r_sqx        <= r_side0.xm * r_side0.xm;
            r_sqy        <= r_side0.ym * r_side0.ym;
            r_side2      <= r_side1;
            r_rad        <= r_sqx + r_sqy;
        end
    end

    vn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_rad   (r_rad),
        .i_side  (r_side2),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    // lane flags
    assign w_tagx_in = '{semi: w_side.semi, mag_nz: (w_side.xm != '0), neg: w_side.xneg};
    assign w_tagy_in = '{semi: w_side.semi, mag_nz: (w_side.ym != '0), neg: w_side.yneg};

    vn_div_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_mag   (w_side.xm),
        .i_len   (w_root),
        .i_tag   (w_tagx_in),
        .o_valid (w_dx_valid),
        .o_q     (w_qx),
        .o_len   (w_len),
        .o_tag   (w_tagx)
    );

    vn_div_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_mag   (w_side.ym),
        .i_len   (w_root),
        .i_tag   (w_tagy_in),
        .o_valid (),
        .o_q     (w_qy),
        .o_len   (),
        .o_tag   (w_tagy)
    );

    vn_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dx_valid),
        .i_qx    (w_qx),
        .i_qy    (w_qy),
        .i_tagx  (w_tagx),
        .i_tagy  (w_tagy),
        .i_len   (w_len),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/vn_sqrt.sv
// Pipelined floor square root, one root bit per stage, with sideband.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vn_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [vn_pkg::SQ_W-1:0]   i_rad,
    input  wire vn_pkg::t_side             i_side,
    output logic                           o_valid,
    output logic [vn_pkg::ROOT_W-1:0]      o_root,
    output vn_pkg::t_side                  o_side
);

    localparam int N = vn_pkg::ROOT_W;

    logic                      r_valid [0:N-1];
    logic [vn_pkg::SQ_W-1:0]   r_rad  [0:N-1];
    logic [vn_pkg::REM_W-1:0]  r_rem  [0:N-1];
    logic [vn_pkg::ROOT_W-1:0] r_root [0:N-1];
    vn_pkg::t_side             r_side [0:N-1];
    vn_pkg::t_sq_step          n_st   [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_st
        if (k == 0) begin : g_first
            // seed the recurrence from the top bit pair
            assign n_st[k] = vn_pkg::sqrt_step('0, '0, i_rad[vn_pkg::SQ_W-1 -: 2]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= i_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k]  <= i_rad << 2;
                    r_side[k] <= i_side;
                end
            end
        end else begin : g_next
            // advance one bit pair
            assign n_st[k] = vn_pkg::sqrt_step(r_rem[k-1], r_root[k-1],
                                               r_rad[k-1][vn_pkg::SQ_W-1 -: 2]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k]  <= r_rad[k-1] << 2;
                    r_side[k] <= r_side[k-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_st[k].rem;
                r_root[k] <= n_st[k].root;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/vn_div_lane.sv
// One divider lane: rounded quotient of mag * 2^FRAC_W by len, one bit per stage.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vn_div_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [vn_pkg::IN_W-1:0]   i_mag,
    input  wire logic [vn_pkg::ROOT_W-1:0] i_len,
    input  wire vn_pkg::t_tag              i_tag,
    output logic                           o_valid,
    output logic [vn_pkg::Q_W-1:0]         o_q,
    output logic [vn_pkg::ROOT_W-1:0]      o_len,
    output vn_pkg::t_tag                   o_tag
);

    localparam int N = vn_pkg::Q_W;

    logic [vn_pkg::NUM_W-1:0]  n_num;
    logic                      r_valid [0:N-1];
    logic [N-1:0]              r_low  [0:N-1];
    logic [vn_pkg::ROOT_W-1:0] r_rem  [0:N-1];
    logic [vn_pkg::ROOT_W-1:0] r_len  [0:N-1];
    logic [N-1:0]              r_q    [0:N-1];
    vn_pkg::t_tag              r_tag  [0:N-1];
    vn_pkg::t_div_step         n_st   [0:N-1];

    // scaled numerator plus half the divisor for round to nearest
    assign n_num = {1'b0, i_mag, {vn_pkg::FRAC_W{1'b0}}}
                 + vn_pkg::NUM_W'(i_len >> 1);

    for (genvar k = 0; k < N; k++) begin : g_st
        if (k == 0) begin : g_first
            // start from the numerator bits above the quotient
            assign n_st[k] = vn_pkg::div_step(n_num[vn_pkg::NUM_W-1 -: vn_pkg::ROOT_W],
                                              i_len, n_num[N-1]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= i_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_low[k] <= n_num[N-1:0] << 1;
                    r_len[k] <= i_len;
                    r_q[k]   <= {{(N-1){1'b0}}, n_st[k].qbit};
                    r_tag[k] <= i_tag;
                end
            end
        end else begin : g_next
            // bring down the next numerator bit
            assign n_st[k] = vn_pkg::div_step(r_rem[k-1], r_len[k-1], r_low[k-1][N-1]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_low[k] <= r_low[k-1] << 1;
                    r_len[k] <= r_len[k-1];
                    r_q[k]   <= {r_q[k-1][N-2:0], n_st[k].qbit};
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_st[k].rem;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_q     = r_q[N-1];
    assign o_len   = r_len[N-1];
    assign o_tag   = r_tag[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/vn_merge.sv
// Merge stage: saturate, apply semi mode, sign and zero length, register result.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vn_merge (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [vn_pkg::Q_W-1:0]    i_qx,
    input  wire logic [vn_pkg::Q_W-1:0]    i_qy,
    input  wire vn_pkg::t_tag              i_tagx,
    input  wire vn_pkg::t_tag              i_tagy,
    input  wire logic [vn_pkg::ROOT_W-1:0] i_len,
    output logic                           o_valid,
    output vn_pkg::t_out                   o_data
);

    logic          r_valid;
    vn_pkg::t_out  r_data;
    vn_pkg::t_out  n_data;
    logic          n_zero;

    function automatic logic [vn_pkg::OUT_W-1:0] finish(input logic [vn_pkg::Q_W-1:0] q,
                                                        input vn_pkg::t_tag tag);
        logic [vn_pkg::Q_W-1:0]   s;
        logic [vn_pkg::OUT_W-1:0] w;
        s = (q > vn_pkg::Q_ONE) ? vn_pkg::Q_ONE : q;
        if (tag.semi && tag.mag_nz && (s == '0)) begin
            s = vn_pkg::Q_ONE;
        end
        w = {1'b0, s};
        return tag.neg ? (vn_pkg::OUT_W'(0) - w) : w;
    endfunction

    // combine the two lanes
    always_comb begin
        n_zero             = (i_len == '0);
        n_data.magnitude   = i_len;
        n_data.zero_length = n_zero;
        n_data.unit_x      = n_zero ? '0 : finish(i_qx, i_tagx);
        n_data.unit_y      = n_zero ? '0 : finish(i_qy, i_tagy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire
